// File: rtl/core/tamaz_pkg.sv
package tamaz_pkg;

   localparam int WINDOW_LENGTH = 6;
   localparam int SAMPLE_BITS   = 24;
   localparam int AXES          = 3;

   // running window sum and its magnitude
   localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_LENGTH);
   localparam int ABS_BITS = SUM_BITS;

   // divide by window length as multiply by rounded-up reciprocal and shift
   localparam int DIV_SHIFT    = ABS_BITS + $clog2(WINDOW_LENGTH);
   localparam int DIV_MUL_BITS = ABS_BITS + 1;
   localparam logic [DIV_MUL_BITS-1:0] DIV_MUL =
      DIV_MUL_BITS'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1)
                    / 64'(WINDOW_LENGTH));
   localparam int PROD_BITS = ABS_BITS + DIV_MUL_BITS;

   localparam int LEVEL_BITS    = SAMPLE_BITS + 1;
   localparam int REQ_DATA_BITS = ((AXES * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((AXES * LEVEL_BITS + 7) / 8) * 8;

   // item kinds carried in tuser
   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_CAPTURE = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [LEVEL_BITS-1:0]  level_type;

   typedef struct packed {
      logic shift;           // new sample enters the window
      logic advance;         // pipeline moves one stage
      logic stage2_capture;  // item in stage 2 is a zero capture
      logic retire_capture;  // zero capture leaves stage 2 this cycle
   } lane_ctl_type;

endpackage

// File: rtl/core/tamaz_lane.sv
module tamaz_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  tamaz_pkg::lane_ctl_type ctl,
   input  tamaz_pkg::sample_type sample,
   output tamaz_pkg::level_type  level
);

   localparam int L  = tamaz_pkg::WINDOW_LENGTH;
   localparam int SB = tamaz_pkg::SUM_BITS;

   tamaz_pkg::sample_type win_ff [L];
   tamaz_pkg::sample_type win_in [L];
   logic signed [SB-1:0] sum_ff, sum_in;

   logic [tamaz_pkg::ABS_BITS-1:0]  sum_abs;
   logic [tamaz_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   logic                            neg_ff;

   logic [tamaz_pkg::SAMPLE_BITS-1:0] mean_mag;
   logic [tamaz_pkg::LEVEL_BITS-1:0]  mag_ext;
   tamaz_pkg::level_type              mean_ext;
   tamaz_pkg::level_type              offset_ff, offset_in;

   // window shift, oldest reading in entry zero
   always_comb begin
      for (int i = 0; i < L - 1; i++) begin
         win_in[i] = win_ff[i + 1];
      end
      win_in[L-1] = sample;
   end

   assign sum_in = sum_ff - SB'(win_ff[0]) + SB'(sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < L; i++) begin
            win_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else if (ctl.shift) begin
         win_ff <= win_in;
         sum_ff <= sum_in;
      end
   end

   // stage 2: magnitude times reciprocal
   assign sum_abs = sum_ff[SB-1] ? tamaz_pkg::ABS_BITS'(-sum_ff)
                                 : tamaz_pkg::ABS_BITS'(sum_ff);
   assign prod_in = tamaz_pkg::PROD_BITS'(sum_abs)
                  * tamaz_pkg::PROD_BITS'(tamaz_pkg::DIV_MUL);

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         prod_ff <= prod_in;
         neg_ff  <= sum_ff[SB-1];
      end
   end

   // stage 3: truncate toward zero, apply offset
   assign mean_mag = prod_ff[tamaz_pkg::DIV_SHIFT +: tamaz_pkg::SAMPLE_BITS];
   assign mag_ext  = {1'b0, mean_mag};
   assign mean_ext = neg_ff ? -mag_ext : mag_ext;

   assign offset_in = ctl.stage2_capture ? -mean_ext : offset_ff;
   assign level     = mean_ext + offset_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (ctl.retire_capture) begin
         offset_ff <= offset_in;
      end
   end

endmodule

// File: rtl/core/tamaz_merge.sv
module tamaz_merge (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  res_valid,
   input  logic [tamaz_pkg::RSP_DATA_BITS-1:0]   res_data,
   output logic                                  up_ready,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tamaz_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   logic                                out_valid_ff, skid_valid_ff;
   logic [tamaz_pkg::RSP_DATA_BITS-1:0] out_data_ff, skid_data_ff;
   logic                                take;

   assign take       = out_valid_ff & rsp_tready;
   assign up_ready   = ~skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || take) begin
            out_data_ff <= res_data;
         end else begin
            skid_data_ff <= res_data;
         end
      end
   end

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while the output register is empty");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_tready |=> out_valid_ff && !skid_valid_ff
                                      && out_data_ff == $past(skid_data_ff))
      else $error("skid result not moved to the output register");

   a_direct_load: assert property (@(posedge clock) disable iff (reset)
      res_valid && !skid_valid_ff && (!out_valid_ff || rsp_tready)
      |=> out_valid_ff && out_data_ff == $past(res_data))
      else $error("new result not loaded into the output register");

endmodule

// File: rtl/core/three_axis_moving_average_zeroing_unit.sv
// a result passes the running sum, the product register and the output register on its way to rsp_tvalid
// throughput: one item per cycle while the skid entry is free, every stage then takes a new transfer each cycle
// back pressure: a two-entry output stage (register plus skid) absorbs one stall
// reset: synchronous, active high; clears windows, sums, offsets and all valids
module three_axis_moving_average_zeroing_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tamaz_pkg::REQ_DATA_BITS-1:0] req_tdata,   // sample_x, sample_y, sample_z
   input  logic [0:0]                          req_tuser,   // kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tamaz_pkg::RSP_DATA_BITS-1:0] rsp_tdata    // level_x, level_y, level_z, pad
);

   localparam int SB = tamaz_pkg::SAMPLE_BITS;
   localparam int LB = tamaz_pkg::LEVEL_BITS;
   localparam int AX = tamaz_pkg::AXES;

   // whole pipeline moves while the skid entry is free
   logic advance;
   logic accept;

   // stage 1 is the running sum itself, stage 2 the product register
   logic p1_valid_ff, p1_kind_ff;
   logic p2_valid_ff, p2_kind_ff;

   tamaz_pkg::lane_ctl_type lane_ctl;
   tamaz_pkg::level_type    level [AX];
   logic [tamaz_pkg::RSP_DATA_BITS-1:0] res_data;

   assign req_tready = advance;
   assign accept     = req_tvalid & advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= accept;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_kind_ff <= req_tuser[0];
         p2_kind_ff <= p1_kind_ff;
      end
   end

   // a capture transfer leaves the windows alone
   assign lane_ctl.shift          = accept & (req_tuser[0] == tamaz_pkg::KIND_SAMPLE);
   assign lane_ctl.advance        = advance;
   assign lane_ctl.stage2_capture = p2_kind_ff == tamaz_pkg::KIND_CAPTURE;
   assign lane_ctl.retire_capture = advance & p2_valid_ff
                                  & (p2_kind_ff == tamaz_pkg::KIND_CAPTURE);

   // one lane per axis
   for (genvar a = 0; a < AX; a++) begin : g_lane
      tamaz_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl),
         .sample (req_tdata[a*SB +: SB]),
         .level  (level[a])
      );
   end

   // merge lane results into one response word, zero padded
   always_comb begin
      res_data = '0;
      for (int a = 0; a < AX; a++) begin
         res_data[a*LB +: LB] = level[a];
      end
   end

   tamaz_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (p2_valid_ff),
      .res_data   (res_data),
      .up_ready   (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import tamaz_pkg::*;

   // one stimulus item: drain_first holds it back until every level has come out
   typedef struct packed {
      logic       drain_first;
      logic       kind;
      sample_type sz;
      sample_type sy;
      sample_type sx;
   } reading_type;

   typedef struct packed {
      level_type lz;
      level_type ly;
      level_type lx;
   } levels_type;

   localparam sample_type READING_MAX = sample_type'(2 ** (SAMPLE_BITS - 1) - 1);
   localparam sample_type READING_MIN = sample_type'(-(2 ** (SAMPLE_BITS - 1)));

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;   // sample_x, sample_y, sample_z
   logic [0:0]               req_tuser  = KIND_SAMPLE;   // kind
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // level_x, level_y, level_z, pad

   three_axis_moving_average_zeroing_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // filter state mirrored in the testbench
   sample_type hist     [AXES][WINDOW_LENGTH];
   sample_type avg_now  [AXES];
   level_type  zero_ref [AXES];

   reading_type readings_q[$];
   levels_type  levels_due_q[$];

   logic req_taken     = 1'b0;
   int   send_gap      = 0;
   int   stall_left    = 0;
   int   rsp_hold_left = 0;
   bit   rsp_hold_done = 1'b0;
   int   sent_total    = 0;
   int   levels_seen   = 0;
   int   samples_in    = 0;
   int   captures_in   = 0;
   int   mismatches    = 0;

   // shift in one reading per axis or capture the zero reference, return the levels
   function automatic levels_type filter_step(input reading_type rd);
      sample_type fresh [AXES];
      level_type  lvl   [AXES];
      longint     total;
      levels_type res;
      fresh[0] = rd.sx;
      fresh[1] = rd.sy;
      fresh[2] = rd.sz;
      for (int a = 0; a < AXES; a++) begin
         if (rd.kind == KIND_SAMPLE) begin
            total = 0;
            for (int i = 0; i < WINDOW_LENGTH - 1; i++)
               hist[a][i] = hist[a][i+1];
            hist[a][WINDOW_LENGTH-1] = fresh[a];
            for (int i = 0; i < WINDOW_LENGTH; i++)
               total += hist[a][i];
            // signed divide, truncates toward zero
            avg_now[a] = sample_type'(total / WINDOW_LENGTH);
         end else begin
            zero_ref[a] = -level_type'(avg_now[a]);
         end
         lvl[a] = level_type'(avg_now[a]) + zero_ref[a];
      end
      res.lx = lvl[0];
      res.ly = lvl[1];
      res.lz = lvl[2];
      return res;
   endfunction

   function automatic sample_type draw_reading();
      case ($urandom_range(0, 11))
         0: return READING_MAX;
         1: return READING_MIN;
         2: return '0;
         3: return '1;
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic add_reading(input logic kind, input sample_type sx, input sample_type sy,
                              input sample_type sz, input logic drain_first);
      reading_type rd;
      rd.drain_first = drain_first;
      rd.kind        = kind;
      rd.sx          = sx;
      rd.sy          = sy;
      rd.sz          = sz;
      readings_q.push_back(rd);
   endtask

   // idling only outside quiet stretches and never near the end
   function automatic bit idling_on();
      return readings_q.size() > 150 && (sent_total % 300) < 240;
   endfunction

   task automatic check_level(input string axis, input level_type want, input level_type got);
      if (want !== got) begin
         $display("%0t level_%s mismatch: expected %0d, actual %0d", $time, axis, want, got);
         mismatches++;
      end
   endtask

   // request driver, changes on the falling edge
   always @(negedge clock) begin
      reading_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // transfer still pending, hold the item
      end else if (send_gap != 0) begin
         send_gap   <= send_gap - 1;
         req_tvalid <= 1'b0;
      end else if (readings_q.size() == 0 ||
                   (readings_q[0].drain_first && levels_due_q.size() != 0)) begin
         req_tvalid <= 1'b0;
      end else begin
         nxt = readings_q.pop_front();
         req_tvalid <= 1'b1;
         req_tuser  <= nxt.kind;
         req_tdata  <= REQ_DATA_BITS'({nxt.sz, nxt.sy, nxt.sx});
         sent_total <= sent_total + 1;
         // random send gaps, but none while the receiver holds off, so the block backs up
         if (idling_on() && rsp_hold_left == 0 && $urandom_range(0, 3) == 0)
            send_gap <= $urandom_range(1, 8);
      end
   end

   // result receiver: random stall bursts plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_tready    <= 1'b0;
      end else if (!rsp_hold_done && levels_seen >= 200) begin
         rsp_hold_done <= 1'b1;
         rsp_hold_left <= 60;
         rsp_tready    <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idling_on() && $urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predict on every request transfer, check every result transfer
   always @(posedge clock) begin
      reading_type rd;
      levels_type  want;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            rd.drain_first = 1'b0;
            rd.kind        = req_tuser[0];
            rd.sx          = req_tdata[0 +: SAMPLE_BITS];
            rd.sy          = req_tdata[SAMPLE_BITS +: SAMPLE_BITS];
            rd.sz          = req_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
            levels_due_q.push_back(filter_step(rd));
            if (rd.kind == KIND_CAPTURE)
               captures_in++;
            else
               samples_in++;
         end
         if (rsp_tvalid && rsp_tready) begin
            levels_seen++;
            if (levels_due_q.size() == 0) begin
               $display("%0t unexpected result transfer: expected none, actual %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = levels_due_q.pop_front();
               check_level("x", want.lx, rsp_tdata[0 +: LEVEL_BITS]);
               check_level("y", want.ly, rsp_tdata[LEVEL_BITS +: LEVEL_BITS]);
               check_level("z", want.lz, rsp_tdata[2*LEVEL_BITS +: LEVEL_BITS]);
            end
         end
      end
   end

   initial begin
      int guard;
      for (int a = 0; a < AXES; a++) begin
         for (int i = 0; i < WINDOW_LENGTH; i++)
            hist[a][i] = '0;
         avg_now[a]  = '0;
         zero_ref[a] = '0;
      end

      // capture right after reset, sample bits must be ignored
      add_reading(KIND_CAPTURE, sample_type'($urandom), sample_type'($urandom),
                  sample_type'($urandom), 1'b0);
      // partly filled window, negative sums truncating toward zero
      add_reading(KIND_SAMPLE, sample_type'(-7), sample_type'(5), sample_type'(-1), 1'b0);
      add_reading(KIND_SAMPLE, sample_type'(1), sample_type'(-13), sample_type'(-4), 1'b0);
      // window full of the largest reading, then zeroed
      repeat (6) add_reading(KIND_SAMPLE, READING_MAX, READING_MAX, READING_MAX, 1'b0);
      add_reading(KIND_CAPTURE, READING_MIN, READING_MAX, '1, 1'b0);
      // window full of the most negative reading, offset takes its negation
      repeat (6) add_reading(KIND_SAMPLE, READING_MIN, READING_MIN, READING_MIN, 1'b0);
      add_reading(KIND_CAPTURE, '0, '0, '0, 1'b0);
      // mixed signs per axis, level swings against the captured offset
      repeat (3) add_reading(KIND_SAMPLE, READING_MAX, READING_MIN, '1, 1'b0);
      add_reading(KIND_SAMPLE, '0, READING_MAX, READING_MIN, 1'b0);
      add_reading(KIND_CAPTURE, sample_type'($urandom), sample_type'($urandom),
                  sample_type'($urandom), 1'b0);
      add_reading(KIND_SAMPLE, READING_MIN, '0, READING_MAX, 1'b0);

      // random part, with three points where the sender waits for the block to drain
      for (int n = 0; n < 1330; n++) begin
         add_reading(($urandom_range(0, 7) == 0) ? KIND_CAPTURE : KIND_SAMPLE,
                     draw_reading(), draw_reading(), draw_reading(),
                     n == 0 || n == 400 || n == 900);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (readings_q.size() != 0 || req_tvalid)
         @(posedge clock);
      for (guard = 0; guard < 2000 && levels_due_q.size() != 0; guard++)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (levels_due_q.size() != 0) begin
         $display("%0t %0d expected levels never arrived", $time, levels_due_q.size());
         mismatches += levels_due_q.size();
      end

      $display("run covered %0d sample transfers and %0d zero captures, %0d levels checked",
               samples_in, captures_in, levels_seen);
      $display("with stall bursts, one long receiver hold-off and drain pauses; %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("%0t timeout", $time);
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/tamaz_pkg.sv
rtl/core/tamaz_lane.sv
rtl/core/tamaz_merge.sv
rtl/core/three_axis_moving_average_zeroing_unit.sv
tb/tb.sv
